// File: design/adjacency_list_edge_table_top_macros.svh
// assertion macros for the adjacency list edge table
// used by adjacency_list_edge_table_top, no other dependencies
`ifndef ADJACENCY_LIST_EDGE_TABLE_TOP_MACROS_SVH
`define ADJACENCY_LIST_EDGE_TABLE_TOP_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define ALET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ALET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/alet_pkg.sv
// shared codes and controller/datapath command and status types
// for the adjacency list edge table; no dependencies
package alet_pkg;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // configuration register indexes
    localparam logic REG_VERTEX_COUNT  = 1'b0;
    localparam logic REG_WEIGHTED_MODE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       latch;
        logic       clr_wr;
        logic       deg_rd_src;
        logic       deg_rd_dst;
        logic       cap_sd;
        logic       cap_dd;
        logic       ins_wr;
        logic       nb_rd;
        logic       idx_inc;
        logic       rm_last;
        logic       rm_move;
        logic       swap;
        logic       set_res;
        logic [1:0] res_code;
        logic       load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic src_ok;
        logic dst_ok;
        logic is_remove;
        logic undirected;
        logic room;
        logic idx_end;
        logic match;
        logic out_free;
    } t_sts;

endpackage

// File: design/alet_ctrl.sv
// sequencing state machine for the adjacency list edge table
// depends on alet_pkg (t_cmd, t_sts, status codes)
module alet_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  alet_pkg::t_sts  i_sts,
    output alet_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RD_SD   = 4'd2;
    localparam logic [3:0] S_RD_DD   = 4'd3;
    localparam logic [3:0] S_CHECK   = 4'd4;
    localparam logic [3:0] S_INS_WR  = 4'd5;
    localparam logic [3:0] S_RM_RD   = 4'd6;
    localparam logic [3:0] S_RM_CMP  = 4'd7;
    localparam logic [3:0] S_RM_MOVE = 4'd8;
    localparam logic [3:0] S_FINISH  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_phase;
    logic       n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RD_SD;
                end
            end
            S_RD_SD: begin
                o_cmd.deg_rd_src = 1'b1;
                n_state          = S_RD_DD;
            end
            S_RD_DD: begin
                o_cmd.deg_rd_dst = 1'b1;
                o_cmd.cap_sd     = 1'b1;
                n_state          = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.cap_dd  = 1'b1;
                o_cmd.set_res = 1'b1;
                n_phase       = 1'b0;
                if (!i_sts.src_ok || !i_sts.dst_ok) begin
                    o_cmd.res_code = alet_pkg::ST_REJECT;
                    n_state        = S_FINISH;
                end else if (i_sts.is_remove) begin
                    o_cmd.res_code = alet_pkg::ST_DONE;
                    n_state        = S_RM_RD;
                end else if (!i_sts.room) begin
                    o_cmd.res_code = alet_pkg::ST_FULL;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.res_code = alet_pkg::ST_DONE;
                    n_state        = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                if (!r_phase && i_sts.undirected) begin
                    o_cmd.swap = 1'b1;
                    n_phase    = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RM_RD: begin
                if (i_sts.idx_end) begin
                    // reverse edge missing is skipped quietly
                    if (!r_phase) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = alet_pkg::ST_REJECT;
                    end
                    n_state = S_FINISH;
                end else begin
                    o_cmd.nb_rd = 1'b1;
                    n_state     = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (i_sts.match) begin
                    o_cmd.rm_last = 1'b1;
                    n_state       = S_RM_MOVE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RM_RD;
                end
            end
            S_RM_MOVE: begin
                o_cmd.rm_move = 1'b1;
                if (!r_phase && i_sts.undirected) begin
                    o_cmd.swap = 1'b1;
                    n_phase    = 1'b1;
                    n_state    = S_RM_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/alet_dpath.sv
// datapath for the adjacency list edge table: neighbor, weight and degree
// memories, item registers and result register; depends on alet_pkg
module alet_dpath #(
    parameter int VERTICES   = 256,
    parameter int MAX_DEGREE = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  alet_pkg::t_cmd  i_cmd,
    output alet_pkg::t_sts  o_sts,
    input  logic [8:0]      i_vertex_count,
    input  logic            i_weighted_mode,
    input  logic            i_operation,
    input  logic [7:0]      i_source_vertex,
    input  logic [7:0]      i_dest_vertex,
    input  logic            i_directed,
    input  logic [31:0]     i_edge_weight,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [1:0]      o_status,
    output logic [4:0]      o_source_degree
);

    // only vertices reachable by an 8-bit index get storage
    localparam int NV    = (VERTICES > 256) ? 256 : VERTICES;
    localparam int VIW   = $clog2(NV);
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int SLOTS = NV * MAX_DEGREE;
    localparam int SAW   = $clog2(SLOTS);
    localparam logic [8:0] NV_LIM = 9'(NV);

    // item registers
    logic             r_op;
    logic [7:0]       r_src;
    logic [7:0]       r_dst;
    logic             r_dir;
    logic [31:0]      r_weight;
    logic [VIW-1:0]   r_from;
    logic [7:0]       r_to;
    logic [DW-1:0]    r_deg;
    logic [DW-1:0]    r_dd;
    logic [DW-1:0]    r_sdeg;
    logic [DW-1:0]    r_idx;
    logic [1:0]       r_res;
    logic [VIW-1:0]   r_clr;

    // memories
    logic [7:0]       r_nb_mem  [SLOTS];
    logic [31:0]      r_wt_mem  [SLOTS];
    logic [DW-1:0]    r_deg_mem [NV];
    logic [7:0]       r_nb_rdata;
    logic [31:0]      r_wt_rdata;
    logic [DW-1:0]    r_deg_rdata;

    logic             src_ok;
    logic             dst_ok;
    logic             same;
    logic             deg_wr;
    logic [DW-1:0]    w_deg;
    logic [DW-1:0]    slot_sel;
    logic [SAW-1:0]   nb_addr;
    logic             nb_we;
    logic             wt_we;
    logic [7:0]       nb_wdata;
    logic [31:0]      wt_wdata;
    logic [VIW-1:0]   deg_addr;
    logic [DW-1:0]    deg_wdata;
    logic             deg_we;
    logic [DW+1:0]    need_src;
    logic             room;
    logic [8:0]       sdeg_wide;
    logic             out_free;

    assign src_ok = ({1'b0, r_src} < i_vertex_count) && ({1'b0, r_src} < NV_LIM);
    assign dst_ok = ({1'b0, r_dst} < i_vertex_count) && ({1'b0, r_dst} < NV_LIM);
    assign same   = (r_src == r_dst);

    // room check: two slots when an undirected self loop lands in one row
    assign need_src = (!r_dir && same) ? (DW+2)'(2) : (DW+2)'(1);
    always_comb begin
        room = (({2'b00, r_deg} + need_src) <= (DW+2)'(MAX_DEGREE));
        if (!r_dir && !same &&
            (({2'b00, r_deg_rdata} + (DW+2)'(1)) > (DW+2)'(MAX_DEGREE))) begin
            room = 1'b0;
        end
    end

    assign deg_wr = i_cmd.ins_wr || i_cmd.rm_move;
    assign w_deg  = i_cmd.ins_wr ? (r_deg + DW'(1)) : (r_deg - DW'(1));

    // neighbor and weight slot address
    always_comb begin
        if (i_cmd.ins_wr) begin
            slot_sel = r_deg;
        end else if (i_cmd.rm_last) begin
            slot_sel = r_deg - DW'(1);
        end else begin
            slot_sel = r_idx;
        end
    end
    assign nb_addr  = SAW'(r_from) * SAW'(MAX_DEGREE) + SAW'(slot_sel);
    assign nb_we    = deg_wr;
    assign wt_we    = deg_wr && i_weighted_mode;
    assign nb_wdata = i_cmd.ins_wr ? r_to : r_nb_rdata;
    assign wt_wdata = i_cmd.ins_wr ? r_weight : r_wt_rdata;

    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            r_nb_mem[nb_addr] <= nb_wdata;
        end
        r_nb_rdata <= r_nb_mem[nb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            r_wt_mem[nb_addr] <= wt_wdata;
        end
        r_wt_rdata <= r_wt_mem[nb_addr];
    end

    // degree memory address
    always_comb begin
        if (i_cmd.clr_wr) begin
            deg_addr = r_clr;
        end else if (i_cmd.deg_rd_src) begin
            deg_addr = r_src[VIW-1:0];
        end else if (i_cmd.deg_rd_dst) begin
            deg_addr = r_dst[VIW-1:0];
        end else begin
            deg_addr = r_from;
        end
    end
    assign deg_we    = i_cmd.clr_wr || deg_wr;
    assign deg_wdata = i_cmd.clr_wr ? '0 : w_deg;

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            r_deg_mem[deg_addr] <= deg_wdata;
        end
        r_deg_rdata <= r_deg_mem[deg_addr];
    end

    // clear pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + VIW'(1);
        end
    end

    // item and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_operation;
            r_src    <= i_source_vertex;
            r_dst    <= i_dest_vertex;
            r_dir    <= i_directed;
            r_weight <= i_edge_weight;
            r_from   <= i_source_vertex[VIW-1:0];
            r_to     <= i_dest_vertex;
        end else if (i_cmd.swap) begin
            r_from <= r_dst[VIW-1:0];
            r_to   <= r_src;
        end

        if (i_cmd.cap_sd) begin
            r_deg  <= r_deg_rdata;
            r_sdeg <= r_deg_rdata;
        end else if (deg_wr) begin
            if (i_cmd.swap) begin
                r_deg <= same ? w_deg : r_dd;
            end else begin
                r_deg <= w_deg;
            end
            if (r_from == r_src[VIW-1:0]) begin
                r_sdeg <= w_deg;
            end
        end

        if (i_cmd.cap_dd) begin
            r_dd <= r_deg_rdata;
        end

        if (i_cmd.cap_sd || i_cmd.swap) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + DW'(1);
        end

        if (i_cmd.set_res) begin
            r_res <= i_cmd.res_code;
        end
    end

    // result register
    assign out_free  = !o_out_valid || !i_out_stall;
    assign sdeg_wide = 9'(r_sdeg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status        <= r_res;
            o_source_degree <= src_ok ? sdeg_wide[4:0] : 5'd0;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr == VIW'(NV - 1));
        o_sts.src_ok     = src_ok;
        o_sts.dst_ok     = dst_ok;
        o_sts.is_remove  = (r_op == alet_pkg::OP_REMOVE);
        o_sts.undirected = !r_dir;
        o_sts.room       = room;
        o_sts.idx_end    = (r_idx == r_deg);
        o_sts.match      = (r_nb_rdata == r_to);
        o_sts.out_free   = out_free;
    end

endmodule

// File: design/adjacency_list_edge_table_top.sv
// adjacency list edge table, top level: config registers, controller, datapath
// insert reads both degrees, checks, then writes the edge (in both rows when undirected);
// remove searches the row slot by slot through the single-port neighbor memory
// throughput: one item at a time, the next is taken in the cycle after its result is staged
// reset: synchronous active low; a clearing pass over all min(VERTICES,256) entries zeroes
// the degree memory, during which no item is taken (config writes still are)
`include "adjacency_list_edge_table_top_macros.svh"

module adjacency_list_edge_table_top #(
    parameter int VERTICES   = 256,
    parameter int MAX_DEGREE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input beat
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_source_vertex,
    input  logic [7:0]  i_dest_vertex,
    input  logic        i_directed,
    input  logic [31:0] i_edge_weight,
    // result beat
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [4:0]  o_source_degree
);

    logic [8:0]      r_vertex_count;
    logic            r_weighted_mode;
    logic            cfg_wr;
    alet_pkg::t_cmd  cmd;
    alet_pkg::t_sts  sts;

    // config registers, one per word; no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= 9'd256;
            r_weighted_mode <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                alet_pkg::REG_VERTEX_COUNT: begin
                    r_vertex_count <= pwdata[8:0];
                end
                alet_pkg::REG_WEIGHTED_MODE: begin
                    r_weighted_mode <= pwdata[0];
                end
                default: begin
                    r_vertex_count <= r_vertex_count;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            alet_pkg::REG_VERTEX_COUNT:  prdata = {23'd0, r_vertex_count};
            alet_pkg::REG_WEIGHTED_MODE: prdata = {31'd0, r_weighted_mode};
            default:                     prdata = 32'd0;
        endcase
    end

    // input side stalls whenever the sequencer is busy or clearing
    assign o_in_stall = !cmd.in_ready;

    alet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    alet_dpath #(
        .VERTICES   (VERTICES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_vertex_count  (r_vertex_count),
        .i_weighted_mode (r_weighted_mode),
        .i_operation     (i_operation),
        .i_source_vertex (i_source_vertex),
        .i_dest_vertex   (i_dest_vertex),
        .i_directed      (i_directed),
        .i_edge_weight   (i_edge_weight),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_source_degree (o_source_degree)
    );

    // one item in flight: an accepted beat blocks the next
    `ALET_ASSERT_NEXT(a_single_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second beat taken while busy")
    // no result appears the cycle after an item is taken into an empty block
    `ALET_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_in_valid && !o_in_stall && !o_out_valid, !o_out_valid, "result too early")
    // result status is always a defined code
    `ALET_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid, (o_status == alet_pkg::ST_DONE) || (o_status == alet_pkg::ST_REJECT) || (o_status == alet_pkg::ST_FULL), "bad status code")

endmodule
